// ----- rtl/core/b64e_pkg.sv -----
// Shared types, constants and the character table for the base64 stream encoder.
// Depends on nothing; every other file of the encoder imports it.
`timescale 1ns / 1ps

package b64e_pkg;

   localparam int B64E_QUEUE_DEPTH = 2;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] UPPER_BASE = 8'h41;
   localparam logic [7:0] LOWER_BASE = 8'h61;
   localparam logic [7:0] DIGIT_BASE = 8'h30;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;

   localparam logic [5:0] LOWER_FIRST = 6'd26;
   localparam logic [5:0] DIGIT_FIRST = 6'd52;
   localparam logic [5:0] PLUS_INDEX  = 6'd62;

   localparam logic [1:0] LAST_CHAR_INDEX = 2'd3;

   typedef struct packed {
      logic [23:0] group;
      logic [1:0]  held_count;
      logic        final_group;
   } b64e_group_type;

   function automatic logic [7:0] b64e_char(input logic [5:0] index);
      logic [7:0] wide_index;
      wide_index = {2'b00, index};
      if (index < LOWER_FIRST) begin
         return UPPER_BASE + wide_index;
      end else if (index < DIGIT_FIRST) begin
         return LOWER_BASE + (wide_index - {2'b00, LOWER_FIRST});
      end else if (index < PLUS_INDEX) begin
         return DIGIT_BASE + (wide_index - {2'b00, DIGIT_FIRST});
      end else if (index == PLUS_INDEX) begin
         return PLUS_CHAR;
      end else begin
         return SLASH_CHAR;
      end
   endfunction

endpackage

// ----- rtl/core/b64e_front.sv -----
// Front end of the base64 encoder: accepts bytes, holds a partial group
// and forwards each finished group to the group queue. Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_final_byte,
   output logic                    req_full,
   output logic                    q_push,
   output b64e_pkg::b64e_group_type q_entry,
   input  logic                    q_full
);
   import b64e_pkg::*;

   logic [15:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic        accept;
   logic        two_held;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign two_held = held_count_ff[1];

   always_comb begin
      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      q_push        = 1'b0;
      q_entry.final_group = req_final_byte;
      q_entry.held_count  = two_held ? 2'd2 : held_count_ff;
      if (two_held) begin
         q_entry.group = {held_bytes_ff, req_data_byte};
      end else if (held_count_ff == 2'd1) begin
         q_entry.group = {held_bytes_ff[15:8], req_data_byte, 8'h00};
      end else begin
         q_entry.group = {req_data_byte, 16'h0000};
      end
      if (accept) begin
         if (two_held || req_final_byte) begin
            q_push        = 1'b1;
            held_bytes_in = 16'h0000;
            held_count_in = 2'd0;
         end else if (held_count_ff == 2'd1) begin
            held_bytes_in = {held_bytes_ff[15:8], req_data_byte};
            held_count_in = 2'd2;
         end else begin
            held_bytes_in = {req_data_byte, 8'h00};
            held_count_in = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff <= 16'h0000;
         held_count_ff <= 2'd0;
      end else begin
         held_bytes_ff <= held_bytes_in;
         held_count_ff <= held_count_in;
      end
   end

endmodule

// ----- rtl/core/b64e_queue.sv -----
// Short queue of finished three-byte groups between the front and back ends.
// Depends on b64e_pkg for the group entry type.
`timescale 1ns / 1ps

module b64e_queue #(
   parameter int DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  b64e_pkg::b64e_group_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output b64e_pkg::b64e_group_type head_entry,
   output logic                     empty
);
   import b64e_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   b64e_group_type    entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign empty      = (count_ff == '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/core/b64e_back.sv -----
// Back end: turns each queued group into four base64 characters, one per cycle
// while results are popped, via a registered result stage. Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_back (
   input  logic                     clock,
   input  logic                     reset,
   input  b64e_pkg::b64e_group_type head_entry,
   input  logic                     q_empty,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [7:0]               rsp_code_char,
   output logic                     rsp_run_last,
   output logic                     rsp_message_end
);
   import b64e_pkg::*;

   logic [1:0] char_idx_ff, char_idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_run_last_ff, out_run_last_in;
   logic       out_end_ff, out_end_in;
   logic       load;
   logic       last_char;
   logic [5:0] six_bits;
   logic [2:0] sig_count;

   assign load      = !q_empty && (!out_valid_ff || rsp_pop);
   assign last_char = (char_idx_ff == LAST_CHAR_INDEX);
   assign sig_count = {1'b0, head_entry.held_count} + 3'd2;
   assign q_pop     = load && last_char;

   always_comb begin
      case (char_idx_ff)
         2'd0:    six_bits = head_entry.group[23:18];
         2'd1:    six_bits = head_entry.group[17:12];
         2'd2:    six_bits = head_entry.group[11:6];
         default: six_bits = head_entry.group[5:0];
      endcase
   end

   always_comb begin
      char_idx_in     = char_idx_ff;
      out_valid_in    = out_valid_ff && !rsp_pop;
      out_char_in     = out_char_ff;
      out_run_last_in = out_run_last_ff;
      out_end_in      = out_end_ff;
      if (load) begin
         char_idx_in     = char_idx_ff + 1'b1;
         out_valid_in    = 1'b1;
         out_char_in     = ({1'b0, char_idx_ff} < sig_count) ? b64e_char(six_bits) : PAD_CHAR;
         out_run_last_in = last_char;
         out_end_in      = last_char && head_entry.final_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_idx_ff  <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         char_idx_ff  <= char_idx_in;
         out_valid_ff <= out_valid_in;
      end
      out_char_ff     <= out_char_in;
      out_run_last_ff <= out_run_last_in;
      out_end_ff      <= out_end_in;
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_code_char   = out_char_ff;
   assign rsp_run_last    = out_run_last_ff;
   assign rsp_message_end = out_end_ff;

endmodule

// ----- rtl/core/base64_stream_encoder.sv -----
// Base64 stream encoder: a front end that gathers bytes into groups, a group queue,
// and a back end that writes one character per cycle while results are popped.
// The first character of a group reaches the result ports through the group queue
// and then the registered result stage. Throughput, set by the back end, is one
// character per cycle while results are popped: four characters per three bytes.
// Synchronous reset empties the queue and result stage and clears any held bytes.
`timescale 1ns / 1ps

module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_code_char,
   output logic       rsp_run_last,
   output logic       rsp_message_end
);
   import b64e_pkg::*;

   b64e_group_type push_entry;
   b64e_group_type head_entry;
   logic           q_push;
   logic           q_full;
   logic           q_pop;
   logic           q_empty;

   b64e_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .req_full       (req_full),
      .q_push         (q_push),
      .q_entry        (push_entry),
      .q_full         (q_full)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_entry (head_entry),
      .empty      (q_empty)
   );

   b64e_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_entry      (head_entry),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_code_char   (rsp_code_char),
      .rsp_run_last    (rsp_run_last),
      .rsp_message_end (rsp_message_end)
   );

endmodule

// ----- rtl/core/b64e_checker.sv -----
// Port-level checks for the base64 stream encoder, attached by a bind statement.
// Depends on b64e_pkg and the top level base64_stream_encoder.
`timescale 1ns / 1ps

module b64e_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_code_char,
   input logic       rsp_run_last,
   input logic       rsp_message_end
);
   import b64e_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty && !req_full)
      else $error("Encoder not empty after reset.");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_message_end |-> rsp_run_last)
      else $error("Message end on a character that does not close its run.");

   a_pad_follows_pad: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && !rsp_run_last && rsp_code_char == PAD_CHAR
      |=> !rsp_empty && rsp_code_char == PAD_CHAR)
      else $error("Padding not continued to the end of the group.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_code_char)
      && $stable(rsp_run_last) && $stable(rsp_message_end))
      else $error("Stalled transaction changed on the result ports.");

endmodule

bind base64_stream_encoder b64e_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_code_char   (rsp_code_char),
   .rsp_run_last    (rsp_run_last),
   .rsp_message_end (rsp_message_end)
);
